### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by lsab_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, off while rst_n is low.
`define LSAB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define LSAB_ASSERT_NEXT(label, ante, cons, msg) \
    `LSAB_ASSERT(label, (ante) |=> (cons), msg)

`endif

### hdl/lsab_pkg.sv
// ----------------------------------------------------------------------------
// lsab_pkg
// Widths, constants and types of the average brightness core.
// ----------------------------------------------------------------------------
package lsab_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int LIMIT_W    = 8;
    localparam int BRIGHT_W   = 8;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 8;

    localparam int WINDOW     = 16;
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [SUM_W-1:0]  WIN_DIV   = SUM_W'(WINDOW);

    // limits are in sample units / 16
    localparam int LIMIT_SHIFT = 4;
    localparam int DIVD_W      = SAMPLE_W + LIMIT_SHIFT;
    localparam int CNT_W       = $clog2(DIVD_W);

    localparam logic [CFG_ADDR_W-1:0] REG_BRIGHT = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_DARK   = CFG_ADDR_W'(1);

    localparam logic [LIMIT_W-1:0] BRIGHT_RST = LIMIT_W'(80);
    localparam logic [LIMIT_W-1:0] DARK_RST   = LIMIT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_HOLD
    } state_t;

endpackage

### hdl/lsab_window.sv
// ----------------------------------------------------------------------------
// lsab_window
// Ring of past samples with running sum and floored average.
// ----------------------------------------------------------------------------
module lsab_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [lsab_pkg::SAMPLE_W-1:0] sample,
    output logic [lsab_pkg::SAMPLE_W-1:0] average
);
    import lsab_pkg::*;

    logic [SAMPLE_W-1:0] history_reg [WINDOW];
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    avg_full;

    always_comb
    begin
        slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
        sum_next  = sum_reg - SUM_W'(history_reg[slot_reg]) + SUM_W'(sample);
        avg_full  = sum_reg / WIN_DIV;
    end

    assign average = avg_full[SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                history_reg[i] <= '0;
            end
            slot_reg <= '0;
            sum_reg  <= '0;
        end
        else if (push)
        begin
            history_reg[slot_reg] <= sample;
            slot_reg              <= slot_next;
            sum_reg               <= sum_next;
        end
    end

endmodule

### hdl/lsab_divider.sv
// ----------------------------------------------------------------------------
// lsab_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsab_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        done,
    input  logic [lsab_pkg::DIVD_W-1:0] dividend,
    input  logic [lsab_pkg::LIMIT_W-1:0] divisor,
    output logic [lsab_pkg::DIVD_W-1:0] quotient
);
    import lsab_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [LIMIT_W-1:0]  rem_reg;
    logic [LIMIT_W-1:0]  rem_next;
    logic [DIVD_W-1:0]   quo_reg;
    logic [DIVD_W-1:0]   quo_next;
    logic [LIMIT_W-1:0]  dsr_reg;
    logic [LIMIT_W:0]    rem_shift;
    logic [LIMIT_W:0]    rem_diff;
    logic                fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVD_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        fits      = (rem_shift >= {1'b0, dsr_reg});
        rem_next  = fits ? rem_diff[LIMIT_W-1:0] : rem_shift[LIMIT_W-1:0];
        quo_next  = {quo_reg[DIVD_W-2:0], fits};
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

### hdl/light_sensor_average_brightness_core.sv
// ----------------------------------------------------------------------------
// light_sensor_average_brightness_core
// Moving average of light-sensor samples with linear brightness rescale.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     sample
//   out      output     out_valid / out_ready   average, brightness
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item passes through acceptance, a setup state, the bit-serial divider
// (one quotient bit per cycle), taking of the quotient, and the hand-over
// to the output register; a new item is accepted only after that hand-over.
// Reset clears the sample ring and sum; limits return to 80 and 1.
// A finished result waits in the output register while the next item runs;
// a second finished result holds the core until the first is taken.
// ----------------------------------------------------------------------------
module light_sensor_average_brightness_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lsab_pkg::SAMPLE_W-1:0]    sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lsab_pkg::SAMPLE_W-1:0]    average,
    output logic [lsab_pkg::BRIGHT_W-1:0]    brightness,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsab_pkg::CFG_ADDR_W-1:0]  cfg_index,
    input  logic [lsab_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lsab_pkg::*;

    state_t                state_reg;
    state_t                state_next;

    logic [LIMIT_W-1:0]    bright_reg;
    logic [LIMIT_W-1:0]    bright_next;
    logic [LIMIT_W-1:0]    dark_reg;
    logic [LIMIT_W-1:0]    dark_next;

    logic                  push;
    logic [SAMPLE_W-1:0]   avg;

    logic [SAMPLE_W:0]     diff;
    logic [SAMPLE_W-1:0]   diff_mag;
    logic [LIMIT_W:0]      span;
    logic [LIMIT_W-1:0]    span_mag;
    logic [DIVD_W-1:0]     dividend;

    logic                  neg_reg;
    logic                  zero_reg;

    logic                  div_start;
    logic                  div_done;
    logic [DIVD_W-1:0]     quotient;
    logic [BRIGHT_W-1:0]   bright_val;

    logic [SAMPLE_W-1:0]   res_avg_reg;
    logic [BRIGHT_W-1:0]   res_bright_reg;
    logic                  load_res;
    logic                  load_out;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [SAMPLE_W-1:0]   average_reg;
    logic [BRIGHT_W-1:0]   brightness_reg;

    assign push      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    lsab_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .sample  (sample),
        .average (avg)
    );

    // signed magnitudes of (avg - dark*16) and (bright - dark)
    always_comb
    begin
        diff     = {1'b0, avg} - {1'b0, dark_reg, {LIMIT_SHIFT{1'b0}}};
        diff_mag = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
        span     = {1'b0, bright_reg} - {1'b0, dark_reg};
        span_mag = span[LIMIT_W] ? LIMIT_W'(-span) : span[LIMIT_W-1:0];
        dividend = {diff_mag, {LIMIT_SHIFT{1'b0}}};
    end

    lsab_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .done     (div_done),
        .dividend (dividend),
        .divisor  (span_mag),
        .quotient (quotient)
    );

    always_comb
    begin
        if (neg_reg || zero_reg)
        begin
            bright_val = '0;
        end
        else if (|quotient[DIVD_W-1:BRIGHT_W])
        begin
            bright_val = '1;
        end
        else
        begin
            bright_val = quotient[BRIGHT_W-1:0];
        end
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        load_res   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    load_res   = 1'b1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bright_next = bright_reg;
        dark_next   = dark_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BRIGHT: bright_next = cfg_data[LIMIT_W-1:0];
                REG_DARK:   dark_next   = cfg_data[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bright_reg    <= BRIGHT_RST;
            dark_reg      <= DARK_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bright_reg    <= bright_next;
            dark_reg      <= dark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            neg_reg     <= diff[SAMPLE_W] ^ span[LIMIT_W];
            zero_reg    <= (diff_mag == '0);
            res_avg_reg <= avg;
        end
        if (load_res)
        begin
            res_bright_reg <= bright_val;
        end
        if (load_out)
        begin
            average_reg    <= res_avg_reg;
            brightness_reg <= res_bright_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign average    = average_reg;
    assign brightness = brightness_reg;

endmodule

### hdl/lsab_checker.sv
// ----------------------------------------------------------------------------
// lsab_checker
// Port-level checks of the average brightness core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsab_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [lsab_pkg::SAMPLE_W-1:0] average,
    input  logic [lsab_pkg::BRIGHT_W-1:0] brightness
);
    import lsab_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // one item in flight at a time
    `LSAB_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready, "item accepted back to back")

    // no result without an item behind it
    `LSAB_ASSERT(a_no_extra_result, out_valid |-> (pend_reg != 2'd0), "result without item")

    // at most one item running and one result waiting
    `LSAB_ASSERT(a_pend_bound, pend_reg != 2'd3, "item count out of range")

    // stalled result holds
    `LSAB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(average) && $stable(brightness), "stalled result changed")

endmodule

bind light_sensor_average_brightness_core lsab_checker u_lsab_checker (.*);

### tb/light_sensor_average_brightness_checker.sv
// ----------------------------------------------------------------------------
// light_sensor_average_brightness_checker
// Watches the sample, result and register channels of the average brightness
// core. It keeps its own sample ring, running sum and limits, predicts the
// average and brightness of every accepted sample, and compares each accepted
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module light_sensor_average_brightness_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [lsab_pkg::SAMPLE_W-1:0]    sample,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [lsab_pkg::SAMPLE_W-1:0]    average,
    input  logic [lsab_pkg::BRIGHT_W-1:0]    brightness,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [lsab_pkg::CFG_ADDR_W-1:0]  cfg_index,
    input  logic [lsab_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               readings_due
);
    import lsab_pkg::*;

    localparam int BRIGHT_STEPS = 256;
    localparam int BRIGHT_MAX   = 255;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [BRIGHT_W-1:0] brightness;
    } reading_t;

    reading_t            pending_readings [$];
    logic [SAMPLE_W-1:0] ring [WINDOW];
    logic [SUM_W-1:0]    ring_sum;
    logic [SLOT_W-1:0]   slot;
    logic [LIMIT_W-1:0]  bright_lim;
    logic [LIMIT_W-1:0]  dark_lim;
    int                  errs = 0;

    function automatic logic [BRIGHT_W-1:0] rescale_brightness(
        input logic [SAMPLE_W-1:0] avg
    );
        int floor_v;
        int num;
        int den;
        int q;
        floor_v = int'(dark_lim) << LIMIT_SHIFT;
        num = (int'(avg) - floor_v) * BRIGHT_STEPS;
        den = (int'(bright_lim) - int'(dark_lim)) << LIMIT_SHIFT;
        if (den == 0)
            return (int'(avg) > floor_v) ? BRIGHT_W'(BRIGHT_MAX) : '0;
        q = num / den;
        if (q > BRIGHT_MAX)
            return BRIGHT_W'(BRIGHT_MAX);
        if (q < 0)
            return '0;
        return BRIGHT_W'(q);
    endfunction

    always @(posedge clk)
    begin
        reading_t            got;
        reading_t            want;
        logic [SAMPLE_W-1:0] avg_now;
        if (!rst_n)
        begin
            foreach (ring[i])
                ring[i] = '0;
            ring_sum   = '0;
            slot       = '0;
            bright_lim = BRIGHT_RST;
            dark_lim   = DARK_RST;
            pending_readings.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BRIGHT)
                    bright_lim = cfg_data;
                else if (cfg_index == REG_DARK)
                    dark_lim = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                got = '{average: average, brightness: brightness};
                if (pending_readings.size() == 0)
                begin
                    $display("%0t checker: unexpected result average %0d brightness %0d",
                             $time, got.average, got.brightness);
                    errs++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.average !== want.average)
                    begin
                        $display("%0t checker: average expected %0d got %0d",
                                 $time, want.average, got.average);
                        errs++;
                    end
                    if (got.brightness !== want.brightness)
                    begin
                        $display("%0t checker: brightness expected %0d got %0d",
                                 $time, want.brightness, got.brightness);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                ring_sum   = ring_sum - SUM_W'(ring[slot]) + SUM_W'(sample);
                ring[slot] = sample;
                slot       = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
                avg_now    = SAMPLE_W'(ring_sum / WIN_DIV);
                pending_readings.push_back('{average: avg_now,
                                             brightness: rescale_brightness(avg_now)});
            end
        end
        readings_due <= pending_readings.size();
        mismatches   <= errs;
    end

endmodule

### tb/light_sensor_average_brightness_core_tb.sv
// ----------------------------------------------------------------------------
// light_sensor_average_brightness_core_tb
// Drives samples and limit writes into the average brightness core: a warm-up
// run at reset limits, then phases at wide, inverted, zero-span, reset and
// random limits, each with runs of samples near the limits, at the rails and
// at random. Sender bursts and receiver stall patterns vary; one long receiver
// hold fills the core. The checker beside the core does all comparing.
// ----------------------------------------------------------------------------
module light_sensor_average_brightness_core_tb;
    import lsab_pkg::*;

    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    localparam int DRAIN        = 25;
    localparam int RX_HOLD      = 400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 138;

    typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;
    typedef enum {RUN_NOISE, RUN_DARK_EDGE, RUN_BRIGHT_EDGE, RUN_RAIL, RUN_LEVEL} run_kind_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    sample = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SAMPLE_W-1:0]    average;
    logic [BRIGHT_W-1:0]    brightness;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int   mismatches;
    int   readings_due;
    int   quiet_cycles = 0;
    int   burst_left = 0;
    int   bright_set = BRIGHT_RST;
    int   dark_set = DARK_RST;
    logic rx_hold_req = 1'b0;

    light_sensor_average_brightness_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .average    (average),
        .brightness (brightness),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    light_sensor_average_brightness_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .average      (average),
        .brightness   (brightness),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .readings_due (readings_due)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT - 1)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver
    initial
    begin
        rx_mode_t mode;
        int       left;
        mode = RX_FREE;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
            end
            if (left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                RX_FREE:   out_ready <= 1'b1;
                RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= (left % 5 != 0);
            endcase
        end
    end

    task automatic send_sample(input int value);
        int gap;
        in_valid <= 1'b1;
        sample   <= SAMPLE_W'(value);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 30);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_due != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_limits(input int hi, input int lo, input logic [CFG_ADDR_W-1:0] junk_idx);
        write_reg(REG_BRIGHT, CFG_DATA_W'(hi));
        write_reg(REG_DARK, CFG_DATA_W'(lo));
        write_reg(junk_idx, CFG_DATA_W'($urandom));
        cfg_valid  <= 1'b0;
        bright_set = hi;
        dark_set   = lo;
    endtask

    task automatic play_runs(input int count);
        int        sent;
        int        run_len;
        int        base;
        int        v;
        int        r;
        run_kind_t kind;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 9);
            kind = (r < 3) ? RUN_NOISE : (r == 3) ? RUN_DARK_EDGE :
                   (r == 4) ? RUN_BRIGHT_EDGE : (r == 5) ? RUN_RAIL : RUN_LEVEL;
            run_len = $urandom_range(1, 24);
            case (kind)
                RUN_DARK_EDGE:   base = (dark_set << LIMIT_SHIFT) + $urandom_range(0, 8) - 4;
                RUN_BRIGHT_EDGE: base = (bright_set << LIMIT_SHIFT) + $urandom_range(0, 8) - 4;
                RUN_RAIL:        base = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
                default:         base = $urandom_range(0, SAMPLE_MAX);
            endcase
            for (int i = 0; i < run_len && sent < count; i++)
            begin
                if (kind == RUN_NOISE)
                    v = $urandom_range(0, SAMPLE_MAX);
                else if ($urandom_range(0, 3) == 0)
                    v = base + $urandom_range(0, 6) - 3;
                else
                    v = base;
                v = (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
                send_sample(v);
                sent++;
            end
        end
    endtask

    initial
    begin
        int hi;
        int lo;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 40);

        // warm-up at reset limits: zeroed ring pulls the average down
        send_sample(0);
        send_sample(SAMPLE_MAX);
        send_sample(1);
        send_sample(2048);
        repeat (12) send_sample(SAMPLE_MAX);
        repeat (8) send_sample(0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: begin hi = 255; lo = 0;   end
                1: begin hi = 0;   lo = 255; end
                2: begin hi = 0;   lo = 0;   end
                3: begin hi = 255; lo = 255; end
                4: begin hi = 100; lo = 100; end
                5: begin hi = BRIGHT_RST; lo = DARK_RST; end
                6: begin hi = 50;  lo = 200; end
                default:
                begin
                    hi = $urandom_range(0, 255);
                    lo = $urandom_range(0, 255);
                end
            endcase
            set_limits(hi, lo, (p % 2) ? CFG_ADDR_W'(255) : CFG_ADDR_W'($urandom_range(2, 254)));
            if (p == 1)
            begin
                rx_hold_req = 1'b1;
                burst_left  = 40;
            end
            play_runs(PHASE_ITEMS);
        end

        wait_idle();
        if (mismatches == 0 && readings_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/lsab_pkg.sv
hdl/lsab_window.sv
hdl/lsab_divider.sv
hdl/light_sensor_average_brightness_core.sv
hdl/lsab_checker.sv
tb/light_sensor_average_brightness_checker.sv
tb/light_sensor_average_brightness_core_tb.sv
